@@ hw/rtl/ogd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ogd_pkg;

  // signed Q3.16 working format (20 bits), 65536 = 1.0
  typedef logic signed [19:0] coord_t;

  typedef struct packed {
    logic        neg;
    logic [16:0] mag;
  } comp_t;

  localparam coord_t ONE_Q16 = 20'sd65536;

  localparam int CDIV_STEPS = 18;  // cell coordinate quotient bits
  localparam int SQRT_STEPS = 25;  // root bits of the 50-bit squared length
  localparam int SDIV_STEPS = 18;  // output scaling quotient bits

  localparam logic [1:0] REG_GRID_SIZE   = 2'd0;
  localparam logic [1:0] REG_LAYOUT_MODE = 2'd1;

  localparam logic LAYOUT_FULL = 1'b0;
  localparam logic LAYOUT_HEMI = 1'b1;

  localparam logic [6:0]  GRID_SIZE_RST = 7'd16;
  localparam logic [17:0] SAT_POS       = 18'd32767;
  localparam logic [17:0] SAT_NEG       = 18'd32768;

endpackage

`default_nettype wire

@@ hw/rtl/octahedral_grid_direction_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Octahedral grid direction unit.
// Input stream (s_axis_*) carries one grid cell per transfer; the output stream
// (m_axis_*) returns one unit direction, Q1.15 per component, per cell, in order.
// grid_size and layout_mode are written through the cfg_* channel (always ready);
// the user must write them only while the unit is idle; the unit does not enforce it.
// From input transfer to output valid a cell passes the input register,
// 18 stages of the cell coordinate divider, 3 decode/square/sum stages, 25 stages
// of the square root, the length register, 18 stages of the output scaling
// divider and the output register.
// Throughput is one cell per cycle while the output is not stalled; every stage
// is a register, so items follow back to back.
// When the receiver drops m_axis_tready with a result held at the output, the
// whole pipeline freezes and s_axis_tready falls in the same cycle; nothing is
// lost or repeated. Empty stages keep moving while the output is empty.
// Reset clears the valid bits of every stage and loads grid_size 16, full
// sphere layout.
module octahedral_grid_direction_unit #(
  parameter int GRID_LIMIT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // cell_x[5:0], cell_y[11:6], zero pad
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o    // dir_x[15:0], dir_y[31:16], dir_z[47:32]
);

  localparam int NSTG = ogd_pkg::CDIV_STEPS + ogd_pkg::SQRT_STEPS
                      + ogd_pkg::SDIV_STEPS + 6;
  localparam int CD = ogd_pkg::CDIV_STEPS;
  localparam int SQ = ogd_pkg::SQRT_STEPS;
  localparam int SD = ogd_pkg::SDIV_STEPS;
  localparam logic [10:0] LIMIT = 11'(GRID_LIMIT);

  // configuration
  logic [6:0] grid_size_q;
  logic       layout_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q   <= ogd_pkg::GRID_SIZE_RST;
      layout_mode_q <= ogd_pkg::LAYOUT_FULL;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ogd_pkg::REG_GRID_SIZE:   grid_size_q   <= cfg_data_i;
        ogd_pkg::REG_LAYOUT_MODE: layout_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTG-1:0] vld_q;
  logic            en;

  assign en              = m_axis_tready_i || !vld_q[NSTG-1];
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid_i};
    end
  end

  // stage 0: divisor and clamped indices
  logic [6:0] size_c, d_c, ix_c, iy_c;

  always_comb begin
    size_c = ({4'b0, grid_size_q} > LIMIT) ? LIMIT[6:0] : grid_size_q;
    d_c    = (size_c <= 7'd1) ? 7'd1 : size_c - 7'd1;
    ix_c   = ({1'b0, s_axis_tdata_i[5:0]} > d_c) ? d_c : {1'b0, s_axis_tdata_i[5:0]};
    iy_c   = ({1'b0, s_axis_tdata_i[11:6]} > d_c) ? d_c : {1'b0, s_axis_tdata_i[11:6]};
  end

  // coordinate divider: (i*2^18 + d) / (2d), one quotient bit per stage
  logic [7:0]  cdv_q  [CD+1];
  logic [7:0]  cxr_q  [CD+1];
  logic [7:0]  cyr_q  [CD+1];
  logic [17:0] cxn_q  [CD+1];
  logic [17:0] cyn_q  [CD+1];
  logic [17:0] cxq_q  [CD+1];
  logic [17:0] cyq_q  [CD+1];
  logic [7:0]  cxr_d  [CD];
  logic [7:0]  cyr_d  [CD];
  logic [17:0] cxq_d  [CD];
  logic [17:0] cyq_d  [CD];

  always_comb begin
    logic [8:0] tx;
    logic [8:0] ty;
    for (int k = 0; k < CD; k++) begin
      tx = {cxr_q[k], cxn_q[k][17]};
      ty = {cyr_q[k], cyn_q[k][17]};
      if (tx >= {1'b0, cdv_q[k]}) begin
        cxr_d[k] = 8'(tx - {1'b0, cdv_q[k]});
        cxq_d[k] = {cxq_q[k][16:0], 1'b1};
      end else begin
        cxr_d[k] = tx[7:0];
        cxq_d[k] = {cxq_q[k][16:0], 1'b0};
      end
      if (ty >= {1'b0, cdv_q[k]}) begin
        cyr_d[k] = 8'(ty - {1'b0, cdv_q[k]});
        cyq_d[k] = {cyq_q[k][16:0], 1'b1};
      end else begin
        cyr_d[k] = ty[7:0];
        cyq_d[k] = {cyq_q[k][16:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cdv_q[0] <= {d_c, 1'b0};
      cxr_q[0] <= {1'b0, ix_c};
      cyr_q[0] <= {1'b0, iy_c};
      cxn_q[0] <= {11'b0, d_c};
      cyn_q[0] <= {11'b0, d_c};
      cxq_q[0] <= '0;
      cyq_q[0] <= '0;
      for (int k = 0; k < CD; k++) begin
        cdv_q[k+1] <= cdv_q[k];
        cxr_q[k+1] <= cxr_d[k];
        cyr_q[k+1] <= cyr_d[k];
        cxn_q[k+1] <= {cxn_q[k][16:0], 1'b0};
        cyn_q[k+1] <= {cyn_q[k][16:0], 1'b0};
        cxq_q[k+1] <= cxq_d[k];
        cyq_q[k+1] <= cyq_d[k];
      end
    end
  end

  // octahedral decode
  ogd_pkg::coord_t u_c, v_c, au_c, av_c, zf_c, hx_c, hy_c, ahx_c, ahy_c;
  ogd_pkg::coord_t x_d, y_d, z_d, x_q, y_q, z_q;

  always_comb begin
    u_c  = $signed({2'b0, cxq_q[CD]}) - ogd_pkg::ONE_Q16;
    v_c  = $signed({2'b0, cyq_q[CD]}) - ogd_pkg::ONE_Q16;
    au_c = u_c[19] ? -u_c : u_c;
    av_c = v_c[19] ? -v_c : v_c;
    zf_c = ogd_pkg::ONE_Q16 - au_c - av_c;
    // arithmetic shift is the floor halving
    hx_c  = (u_c + v_c) >>> 1;
    hy_c  = (u_c - v_c) >>> 1;
    ahx_c = hx_c[19] ? -hx_c : hx_c;
    ahy_c = hy_c[19] ? -hy_c : hy_c;
    if (layout_mode_q == ogd_pkg::LAYOUT_HEMI) begin
      x_d = hx_c;
      y_d = hy_c;
      z_d = ogd_pkg::ONE_Q16 - ahx_c - ahy_c;
    end else if (zf_c[19]) begin
      // lower hemisphere folds over the diagonals
      x_d = u_c[19] ? av_c - ogd_pkg::ONE_Q16 : ogd_pkg::ONE_Q16 - av_c;
      y_d = v_c[19] ? au_c - ogd_pkg::ONE_Q16 : ogd_pkg::ONE_Q16 - au_c;
      z_d = zf_c;
    end else begin
      x_d = u_c;
      y_d = v_c;
      z_d = zf_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  // squares
  ogd_pkg::comp_t cmp_d [3];
  ogd_pkg::comp_t cmp_q [3];
  logic [33:0]    sqr_d [3];
  logic [33:0]    sqr_q [3];
  ogd_pkg::coord_t vec_c [3];

  always_comb begin
    vec_c[0] = x_q;
    vec_c[1] = y_q;
    vec_c[2] = z_q;
    for (int c = 0; c < 3; c++) begin
      cmp_d[c].neg = vec_c[c][19];
      cmp_d[c].mag = vec_c[c][19] ? 17'(-vec_c[c]) : vec_c[c][16:0];
      sqr_d[c]     = {17'b0, cmp_d[c].mag} * {17'b0, cmp_d[c].mag};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        cmp_q[c] <= cmp_d[c];
        sqr_q[c] <= sqr_d[c];
      end
    end
  end

  // square root of sum<<16, one root bit per stage
  logic [26:0]    sqr_rem_q  [SQ+1];
  logic [24:0]    sqr_root_q [SQ+1];
  logic [49:0]    sqr_num_q  [SQ+1];
  ogd_pkg::comp_t sqr_cmp_q  [SQ+1][3];
  logic [26:0]    sqr_rem_d  [SQ];
  logic [24:0]    sqr_root_d [SQ];
  logic [33:0]    sum_c;

  assign sum_c = sqr_q[0] + sqr_q[1] + sqr_q[2];

  always_comb begin
    logic [28:0] t;
    logic [28:0] tr;
    for (int k = 0; k < SQ; k++) begin
      t  = {sqr_rem_q[k], sqr_num_q[k][49:48]};
      tr = {2'b0, sqr_root_q[k], 2'b01};
      if (t >= tr) begin
        sqr_rem_d[k]  = 27'(t - tr);
        sqr_root_d[k] = {sqr_root_q[k][23:0], 1'b1};
      end else begin
        sqr_rem_d[k]  = t[26:0];
        sqr_root_d[k] = {sqr_root_q[k][23:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqr_rem_q[0]  <= '0;
      sqr_root_q[0] <= '0;
      sqr_num_q[0]  <= {sum_c, 16'b0};
      for (int c = 0; c < 3; c++) sqr_cmp_q[0][c] <= cmp_q[c];
      for (int k = 0; k < SQ; k++) begin
        sqr_rem_q[k+1]  <= sqr_rem_d[k];
        sqr_root_q[k+1] <= sqr_root_d[k];
        sqr_num_q[k+1]  <= {sqr_num_q[k][47:0], 2'b00};
        for (int c = 0; c < 3; c++) sqr_cmp_q[k+1][c] <= sqr_cmp_q[k][c];
      end
    end
  end

  // scaling divider: (mag*2^23 + len/2) / len for all three components
  logic [24:0] len_c;
  logic [39:0] snum_c [3];
  logic [24:0] dlen_q [SD+1];
  logic [24:0] drem_q [SD+1][3];
  logic [17:0] dnum_q [SD+1][3];
  logic [17:0] dquo_q [SD+1][3];
  logic [2:0]  dneg_q [SD+1];
  logic [24:0] drem_d [SD][3];
  logic [17:0] dquo_d [SD][3];

  assign len_c = sqr_root_q[SQ];

  always_comb begin
    logic [25:0] t;
    for (int c = 0; c < 3; c++) begin
      snum_c[c] = {sqr_cmp_q[SQ][c].mag, 23'b0} + {16'b0, len_c[24:1]};
    end
    for (int k = 0; k < SD; k++) begin
      for (int c = 0; c < 3; c++) begin
        t = {drem_q[k][c], dnum_q[k][c][17]};
        if (t >= {1'b0, dlen_q[k]}) begin
          drem_d[k][c] = 25'(t - {1'b0, dlen_q[k]});
          dquo_d[k][c] = {dquo_q[k][c][16:0], 1'b1};
        end else begin
          drem_d[k][c] = t[24:0];
          dquo_d[k][c] = {dquo_q[k][c][16:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dlen_q[0] <= len_c;
      for (int c = 0; c < 3; c++) begin
        drem_q[0][c] <= {3'b0, snum_c[c][39:18]};
        dnum_q[0][c] <= snum_c[c][17:0];
        dquo_q[0][c] <= '0;
        dneg_q[0][c] <= sqr_cmp_q[SQ][c].neg;
      end
      for (int k = 0; k < SD; k++) begin
        dlen_q[k+1] <= dlen_q[k];
        dneg_q[k+1] <= dneg_q[k];
        for (int c = 0; c < 3; c++) begin
          drem_q[k+1][c] <= drem_d[k][c];
          dnum_q[k+1][c] <= {dnum_q[k][c][16:0], 1'b0};
          dquo_q[k+1][c] <= dquo_d[k][c];
        end
      end
    end
  end

  // saturation and sign, output register
  logic [17:0] qs_c  [3];
  logic [15:0] dir_d [3];
  logic [15:0] dir_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (dneg_q[SD][c]) begin
        qs_c[c]  = (dquo_q[SD][c] > ogd_pkg::SAT_NEG) ? ogd_pkg::SAT_NEG : dquo_q[SD][c];
        dir_d[c] = 16'(-qs_c[c]);
      end else begin
        qs_c[c]  = (dquo_q[SD][c] > ogd_pkg::SAT_POS) ? ogd_pkg::SAT_POS : dquo_q[SD][c];
        dir_d[c] = qs_c[c][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) dir_q[c] <= dir_d[c];
    end
  end

  assign m_axis_tdata_o = {dir_q[2], dir_q[1], dir_q[0]};

endmodule

`default_nettype wire
